FILE: hdl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/dtq_pkg.sv
// types and codes of the delayed task queue scheduler
// used by every module of the block, depends on nothing

package dtq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_BAD  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TABLE_FULL = 2'd1,
        ERR_RING_FULL  = 2'd2,
        ERR_BAD_CMD    = 2'd3
    } err_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_FIND,
        S_TICK_RD,
        S_TICK_WR,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] code;
        logic [31:0] arg;
    } task_t;

    typedef struct packed {
        task_t       job;
        logic [31:0] count;
    } slot_entry_t;

    typedef struct packed {
        cmd_e        cmd;
        logic [31:0] task_handle;
        logic [31:0] task_code;
        logic [31:0] task_arg;
        logic [31:0] delay_ticks;
    } req_beat_t;

    typedef struct packed {
        logic        popped;
        logic [31:0] out_handle;
        logic [31:0] out_code;
        logic [31:0] out_arg;
        err_e        error;
    } rsp_beat_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic set_used;
        logic clr_used;
    } slot_ctrl_t;

endpackage

FILE: hdl/dtq_ring.sv
// ready ring: task memory with head and tail pointers
// depends on dtq_pkg

module dtq_ring #(
    parameter int READY_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::ring_ctrl_t ctrl,
    input  dtq_pkg::task_t      wr_task,
    output dtq_pkg::task_t      rd_task,
    output dtq_pkg::ring_stat_t stat
);

    localparam int PTR_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(READY_DEPTH - 1);

    dtq_pkg::task_t   mem [READY_DEPTH];
    dtq_pkg::task_t   rd_task_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // push only when not full, pop only when not empty: guarded by the sequencer
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= wr_task;
        end
        if (ctrl.pop)
        begin
            rd_task_reg <= mem[head_reg];
        end
    end

    always_comb
    begin
        head_next = ctrl.pop  ? ptr_inc(head_reg) : head_reg;
        tail_next = ctrl.push ? ptr_inc(tail_reg) : tail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    assign rd_task    = rd_task_reg;
    assign stat.full  = (ptr_inc(tail_reg) == head_reg);
    assign stat.empty = (head_reg == tail_reg);

endmodule

FILE: hdl/dtq_slots.sv
// delay table: slot memory holding task and remaining ticks, plus used flags
// depends on dtq_pkg

module dtq_slots #(
    parameter int DELAY_SLOTS = 8,
    localparam int IDX_W = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtq_pkg::slot_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]     idx,
    input  dtq_pkg::slot_entry_t wr_entry,
    output dtq_pkg::slot_entry_t rd_entry,
    output logic                 used_hit
);

    dtq_pkg::slot_entry_t   mem [DELAY_SLOTS];
    dtq_pkg::slot_entry_t   rd_entry_reg;
    logic [DELAY_SLOTS-1:0] used_reg, used_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[idx] <= wr_entry;
        end
        if (ctrl.rd)
        begin
            rd_entry_reg <= mem[idx];
        end
    end

    // a slot is in use while its count is nonzero
    always_comb
    begin
        used_next = used_reg;
        if (ctrl.set_used)
        begin
            used_next[idx] = 1'b1;
        end
        if (ctrl.clr_used)
        begin
            used_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign used_hit = used_reg[idx];

endmodule

FILE: hdl/delayed_task_queue_scheduler.sv
// channel | beat type           | accepted when
// req     | dtq_pkg::req_beat_t | req_valid & req_ready, only while idle
// rsp     | dtq_pkg::rsp_beat_t | rsp_valid & rsp_ready, one beat per req beat
//
// push with zero delay runs S_PUSH, pop runs S_POP, each then S_DONE; a bad command goes to S_DONE
// delayed push: S_FIND, one used flag checked per cycle, lowest slot first
// tick: S_TICK_RD and S_TICK_WR, one slot memory read-modify-write per used slot
// reset clears pointers and used flags at once, no clearing pass
// a waiting result holds in its register while the next req beat is taken
// top level: sequencer over the ready ring and delay table memories
// depends on dtq_pkg, dtq_ring, dtq_slots

module delayed_task_queue_scheduler #(
    parameter int READY_DEPTH = 16,
    parameter int DELAY_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dtq_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dtq_pkg::rsp_beat_t rsp
);

    localparam int IDX_W = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
    localparam int K_W   = $clog2(DELAY_SLOTS + 1);
    localparam logic [K_W-1:0] K_END  = K_W'(DELAY_SLOTS);
    localparam logic [K_W-1:0] K_LAST = K_W'(DELAY_SLOTS - 1);

    dtq_pkg::state_e      state_reg, state_next;
    dtq_pkg::req_beat_t   req_reg, req_next;
    dtq_pkg::err_e        err_reg, err_next;
    logic                 popped_reg, popped_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    dtq_pkg::rsp_beat_t   rsp_reg, rsp_next;

    dtq_pkg::ring_ctrl_t  ring_ctrl;
    dtq_pkg::ring_stat_t  ring_stat;
    dtq_pkg::task_t       ring_wr_task;
    dtq_pkg::task_t       ring_rd_task;

    dtq_pkg::slot_ctrl_t  slot_ctrl;
    dtq_pkg::slot_entry_t slot_wr_entry;
    dtq_pkg::slot_entry_t slot_rd_entry;
    logic                 slot_used;
    logic [31:0]          count_dec;
    dtq_pkg::task_t       req_task;

    assign req_task  = '{handle: req_reg.task_handle, code: req_reg.task_code,
                         arg: req_reg.task_arg};
    assign count_dec = slot_rd_entry.count - 32'd1;

    dtq_ring #(
        .READY_DEPTH (READY_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .wr_task (ring_wr_task),
        .rd_task (ring_rd_task),
        .stat    (ring_stat)
    );

    dtq_slots #(
        .DELAY_SLOTS (DELAY_SLOTS)
    ) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (slot_ctrl),
        .idx      (k_reg[IDX_W-1:0]),
        .wr_entry (slot_wr_entry),
        .rd_entry (slot_rd_entry),
        .used_hit (slot_used)
    );

    // one access to a memory per cycle and one item at a time, so a read
    // never overlaps a pending write to the same entry
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        err_next       = err_reg;
        popped_next    = popped_reg;
        k_next         = k_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        rsp_next       = rsp_reg;
        ring_ctrl      = '0;
        ring_wr_task   = req_task;
        slot_ctrl      = '0;
        slot_wr_entry  = '{job: req_task, count: req_reg.delay_ticks};
        req_ready      = (state_reg == dtq_pkg::S_IDLE);

        unique case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    err_next    = dtq_pkg::ERR_NONE;
                    popped_next = 1'b0;
                    k_next      = '0;
                    unique case (req.cmd)
                        dtq_pkg::CMD_PUSH:
                            state_next = (req.delay_ticks == 32'd0) ? dtq_pkg::S_PUSH
                                                                    : dtq_pkg::S_FIND;
                        dtq_pkg::CMD_POP:  state_next = dtq_pkg::S_POP;
                        dtq_pkg::CMD_TICK: state_next = dtq_pkg::S_TICK_RD;
                        default:
                        begin
                            err_next   = dtq_pkg::ERR_BAD_CMD;
                            state_next = dtq_pkg::S_DONE;
                        end
                    endcase
                end
            end

            dtq_pkg::S_PUSH:
            begin
                if (ring_stat.full)
                begin
                    err_next = dtq_pkg::ERR_RING_FULL;
                end
                else
                begin
                    ring_ctrl.push = 1'b1;
                end
                state_next = dtq_pkg::S_DONE;
            end

            dtq_pkg::S_POP:
            begin
                // read data lands in the ring's output register for S_DONE
                if (!ring_stat.empty)
                begin
                    ring_ctrl.pop = 1'b1;
                    popped_next   = 1'b1;
                end
                state_next = dtq_pkg::S_DONE;
            end

            dtq_pkg::S_FIND:
            begin
                // lowest free slot wins
                if (!slot_used)
                begin
                    slot_ctrl.wr       = 1'b1;
                    slot_ctrl.set_used = 1'b1;
                    state_next         = dtq_pkg::S_DONE;
                end
                else if (k_reg == K_LAST)
                begin
                    err_next   = dtq_pkg::ERR_TABLE_FULL;
                    state_next = dtq_pkg::S_DONE;
                end
                else
                begin
                    k_next = k_reg + K_W'(1);
                end
            end

            dtq_pkg::S_TICK_RD:
            begin
                if (k_reg == K_END)
                begin
                    state_next = dtq_pkg::S_DONE;
                end
                else if (slot_used)
                begin
                    slot_ctrl.rd = 1'b1;
                    state_next   = dtq_pkg::S_TICK_WR;
                end
                else
                begin
                    k_next = k_reg + K_W'(1);
                end
            end

            dtq_pkg::S_TICK_WR:
            begin
                slot_wr_entry = '{job: slot_rd_entry.job, count: count_dec};
                ring_wr_task  = slot_rd_entry.job;
                slot_ctrl.wr  = 1'b1;
                if (count_dec == 32'd0)
                begin
                    // slot is freed even when the ring has no room
                    slot_ctrl.clr_used = 1'b1;
                    if (ring_stat.full)
                    begin
                        err_next = dtq_pkg::ERR_RING_FULL;
                    end
                    else
                    begin
                        ring_ctrl.push = 1'b1;
                    end
                end
                k_next     = k_reg + K_W'(1);
                state_next = dtq_pkg::S_TICK_RD;
            end

            dtq_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.popped     = popped_reg;
                    rsp_next.out_handle = popped_reg ? ring_rd_task.handle : 32'd0;
                    rsp_next.out_code   = popped_reg ? ring_rd_task.code   : 32'd0;
                    rsp_next.out_arg    = popped_reg ? ring_rd_task.arg    : 32'd0;
                    rsp_next.error      = err_reg;
                    state_next          = dtq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtq_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            err_reg       <= dtq_pkg::ERR_NONE;
            popped_reg    <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            err_reg       <= err_next;
            popped_reg    <= popped_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/dtq_checker.sv
// port-level checks of the delayed task queue scheduler, bound to the top level
// depends on dtq_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input dtq_pkg::req_beat_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input dtq_pkg::rsp_beat_t rsp
);

    // a stalled result beat holds
    `DTQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one item at a time: busy right after a req beat
    `DTQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // a returned task never comes with an error
    `DTQ_ASSERT_NOW(a_pop_no_err, clk, rst_n, rsp_valid && rsp.popped,
        rsp.error == dtq_pkg::ERR_NONE)

    // data fields are zero unless a task was returned
    `DTQ_ASSERT_NOW(a_zero_data, clk, rst_n, rsp_valid && !rsp.popped,
        rsp.out_handle == 32'd0 && rsp.out_code == 32'd0 && rsp.out_arg == 32'd0)

endmodule

bind delayed_task_queue_scheduler dtq_checker u_dtq_checker (.*);

FILE: verif/dtq_checker.sv
// dtq_tb_checker: watches the req and rsp channels of the delayed task queue
// scheduler, predicts every rsp beat and compares it field by field
// depends on dtq_pkg
`timescale 1ns / 100ps

module dtq_tb_checker #(
    parameter int READY_DEPTH = 16,
    parameter int DELAY_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  dtq_pkg::req_beat_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  dtq_pkg::rsp_beat_t rsp,
    output int                 fail_count,
    output int                 pending
);

    dtq_pkg::task_t     ready_mem [READY_DEPTH];
    int unsigned        ready_rd;
    int unsigned        ready_wr;
    dtq_pkg::task_t     wait_job  [DELAY_SLOTS];
    logic [31:0]        wait_left [DELAY_SLOTS];
    dtq_pkg::rsp_beat_t due_rsp_q [$];
    dtq_pkg::rsp_beat_t want;

    function automatic int unsigned ready_after(int unsigned i);
        return (i + 1 >= READY_DEPTH) ? 0 : i + 1;
    endfunction

    // one slot is always kept free, so the ring holds depth minus one tasks
    function automatic bit ready_append(dtq_pkg::task_t t);
        if (ready_after(ready_wr) == ready_rd)
            return 1'b0;
        ready_mem[ready_wr] = t;
        ready_wr = ready_after(ready_wr);
        return 1'b1;
    endfunction

    function automatic dtq_pkg::rsp_beat_t schedule_command(dtq_pkg::req_beat_t b);
        dtq_pkg::rsp_beat_t r;
        dtq_pkg::task_t     t;
        int                 k;
        r        = '0;
        r.error  = dtq_pkg::ERR_NONE;
        t.handle = b.task_handle;
        t.code   = b.task_code;
        t.arg    = b.task_arg;
        case (b.cmd)
            dtq_pkg::CMD_PUSH:
            begin
                if (b.delay_ticks != 32'd0)
                begin
                    k = 0;
                    while (k < DELAY_SLOTS && wait_left[k] != 32'd0)
                        k++;
                    if (k == DELAY_SLOTS)
                        r.error = dtq_pkg::ERR_TABLE_FULL;
                    else
                    begin
                        wait_job[k]  = t;
                        wait_left[k] = b.delay_ticks;
                    end
                end
                else if (!ready_append(t))
                    r.error = dtq_pkg::ERR_RING_FULL;
            end
            dtq_pkg::CMD_POP:
            begin
                if (ready_rd != ready_wr)
                begin
                    r.popped     = 1'b1;
                    r.out_handle = ready_mem[ready_rd].handle;
                    r.out_code   = ready_mem[ready_rd].code;
                    r.out_arg    = ready_mem[ready_rd].arg;
                    ready_rd     = ready_after(ready_rd);
                end
            end
            dtq_pkg::CMD_TICK:
            begin
                // an expiring task that finds the ring full is lost, its slot freed anyway
                for (k = 0; k < DELAY_SLOTS; k++)
                begin
                    if (wait_left[k] != 32'd0)
                    begin
                        wait_left[k] = wait_left[k] - 32'd1;
                        if (wait_left[k] == 32'd0 && !ready_append(wait_job[k]))
                            r.error = dtq_pkg::ERR_RING_FULL;
                    end
                end
            end
            default:
                r.error = dtq_pkg::ERR_BAD_CMD;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
        fail_count++;
        $display("%0t dtq_tb_checker: %s got %h wanted %h", $time, what, got, wanted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_rd = 0;
            ready_wr = 0;
            for (int k = 0; k < DELAY_SLOTS; k++)
                wait_left[k] = 32'd0;
            due_rsp_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            // a rsp beat always belongs to a req beat taken on an earlier edge
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp_q.size() == 0)
                    report_mismatch("rsp beat with nothing pending, handle", rsp.out_handle, '0);
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.popped !== want.popped)
                        report_mismatch("popped", 32'(rsp.popped), 32'(want.popped));
                    if (rsp.out_handle !== want.out_handle)
                        report_mismatch("out_handle", rsp.out_handle, want.out_handle);
                    if (rsp.out_code !== want.out_code)
                        report_mismatch("out_code", rsp.out_code, want.out_code);
                    if (rsp.out_arg !== want.out_arg)
                        report_mismatch("out_arg", rsp.out_arg, want.out_arg);
                    if (rsp.error !== want.error)
                        report_mismatch("error", 32'(rsp.error), 32'(want.error));
                end
            end
            if (req_valid && req_ready)
                due_rsp_q.push_back(schedule_command(req));
            pending = due_rsp_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for the delayed task queue scheduler
// depends on dtq_pkg, delayed_task_queue_scheduler and dtq_tb_checker
`timescale 1ns / 100ps

module tb;

    localparam int READY_DEPTH   = 16;
    localparam int DELAY_SLOTS   = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 210;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    dtq_pkg::req_beat_t req;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    dtq_pkg::rsp_beat_t rsp;

    int fail_count;
    int pending;
    int send_idle   = 0;
    int stall_pct   = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int quiet_cycles = 0;

    delayed_task_queue_scheduler #(
        .READY_DEPTH(READY_DEPTH),
        .DELAY_SLOTS(DELAY_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    dtq_tb_checker #(
        .READY_DEPTH(READY_DEPTH),
        .DELAY_SLOTS(DELAY_SLOTS)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // rsp side: random stalls, or one long hold-off when asked for
    always
    begin
        @(posedge clk);
        if (hold_asked != hold_served)
        begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_served <= hold_served + 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("delayed_task_queue_scheduler: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic dtq_pkg::req_beat_t push_beat(logic [31:0] h, logic [31:0] c,
                                                     logic [31:0] a, logic [31:0] d);
        dtq_pkg::req_beat_t b;
        b.cmd         = dtq_pkg::CMD_PUSH;
        b.task_handle = h;
        b.task_code   = c;
        b.task_arg    = a;
        b.delay_ticks = d;
        return b;
    endfunction

    // fields other than cmd are don't-care here, so they get random bits
    function automatic dtq_pkg::req_beat_t cmd_beat(dtq_pkg::cmd_e c);
        return '{c, $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic dtq_pkg::req_beat_t random_beat(bit filling);
        int unsigned pick;
        int unsigned dly;
        pick = $urandom_range(99);
        if (pick < (filling ? 55 : 20))
        begin
            dly = $urandom_range(9);
            if (dly < 5)
                return push_beat($urandom(), $urandom(), $urandom(), '0);
            else if (dly < 9)
                return push_beat($urandom(), $urandom(), $urandom(), $urandom_range(1, 6));
            else
                return push_beat($urandom(), $urandom(), $urandom(), $urandom_range(1, 40));
        end
        else if (pick < (filling ? 75 : 45))
            return cmd_beat(dtq_pkg::CMD_TICK);
        else if (pick < 92)
            return cmd_beat(dtq_pkg::CMD_POP);
        else
            return cmd_beat(dtq_pkg::CMD_BAD);
    endfunction

    // entered and left at a rising edge; the beat is taken on the last edge
    task automatic send_req(dtq_pkg::req_beat_t b);
        bit taken;
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        do
        begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_all_done();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int idle_set  [4];
        int stall_set [4];
        int sent;
        int burst;
        bit filling;
        idle_set  = '{0, 72, 0, 25};
        stall_set = '{0, 0, 72, 25};
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slot 0 gets the longest delay and stays busy for the whole run
        send_req(push_beat('1, '1, '1, '1));
        send_req(cmd_beat(dtq_pkg::CMD_POP));
        send_req(cmd_beat(dtq_pkg::CMD_BAD));
        send_req(push_beat('0, '0, '0, '0));
        send_req(push_beat('1, '1, '1, '0));
        send_req(cmd_beat(dtq_pkg::CMD_POP));
        send_req(cmd_beat(dtq_pkg::CMD_POP));
        for (int i = 1; i < DELAY_SLOTS; i++)
            send_req(push_beat($urandom(), $urandom(), $urandom(), 32'd1));
        // table is full now
        send_req(push_beat($urandom(), $urandom(), $urandom(), 32'd2));
        // everything but slot 0 expires into the ring in slot order
        send_req(cmd_beat(dtq_pkg::CMD_TICK));
        wait_all_done();

        for (int p = 0; p < 4; p++)
        begin
            send_idle = idle_set[p];
            stall_pct = stall_set[p];
            // receiver holds off while beats keep coming, so the block backs up
            if (p == 0)
                hold_asked <= hold_asked + 1;
            sent    = 0;
            filling = 1'b1;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(10, 50);
                for (int j = 0; j < burst; j++)
                    send_req(random_beat(filling));
                sent    += burst;
                filling = !filling;
            end
            wait_all_done();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("delayed_task_queue_scheduler: match");
        else
            $display("delayed_task_queue_scheduler: mismatch");
        $finish;
    end

endmodule
